// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the k-smallest sum unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SWKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define SWKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/swks_pkg.sv =====
// ---------------------------------------------------------------------------
// swks_pkg
// Sizes, codes and shared types of the sliding-window k-smallest sum unit.
// ---------------------------------------------------------------------------
package swks_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W       = $clog2(MAX_WINDOW);
  localparam int SUM_W       = SAMPLE_BITS + AGE_W;
  localparam int CMP_W       = (CFG_W > LEN_W) ? CFG_W : LEN_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEL,
    ST_INS,
    ST_SUM
  } state_e;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_DELETE,
    OP_INSERT
  } cell_op_e;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_e               op;
    logic [SAMPLE_BITS-1:0] key;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       k;
  } cell_ctrl_t;

  // Contents of one cell, handed to its neighbours
  typedef struct packed {
    logic                   vld;
    logic [SAMPLE_BITS-1:0] val;
    logic [AGE_W-1:0]       age;
  } cell_data_t;

  // Partial sum travelling along the row
  typedef struct packed {
    logic [SUM_W-1:0] acc;
    logic [LEN_W-1:0] cnt;
  } tok_t;

endpackage

// ===== hw/rtl/swks_ram.sv =====
// ---------------------------------------------------------------------------
// swks_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module swks_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/swks_cell.sv =====
// ---------------------------------------------------------------------------
// swks_cell
// One slot of the sorted row: holds a sample and its age, shifts on
// delete and insert, and adds itself to the passing partial sum.
// ---------------------------------------------------------------------------
module swks_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swks_pkg::cell_ctrl_t   ctrl_i,
  input  swks_pkg::cell_data_t   left_i,
  input  swks_pkg::cell_data_t   right_i,
  input  logic                   lt_left_i,
  output logic                   lt_o,
  output swks_pkg::cell_data_t   data_o,
  input  swks_pkg::tok_t         tok_i,
  output swks_pkg::tok_t         tok_o
);

  import swks_pkg::*;

  logic                   vld_q, vld_d;
  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AGE_W-1:0]       age_q, age_d;
  logic                   take_right;
  logic                   in_sum;
  tok_t                   tok_q, tok_d;

  // Row is ordered by value, then by age; the evicted entry is the oldest
  // of its value, so everything from it onwards closes up.
  assign lt_o       = vld_q && (val_q < ctrl_i.key);
  assign take_right = !vld_q || (val_q > ctrl_i.key) ||
                      ((val_q == ctrl_i.key) && (age_q == AGE_W'(MAX_WINDOW - 1)));

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    age_d = age_q;
    unique case (ctrl_i.op)
      OP_NOP: begin
      end
      OP_CLEAR: begin
        vld_d = 1'b0;
      end
      OP_DELETE: begin
        if (take_right) begin
          vld_d = right_i.vld;
          val_d = right_i.val;
          age_d = right_i.age;
        end
      end
      OP_INSERT: begin
        if (lt_o) begin
          age_d = age_q + AGE_W'(1);
        end else if (lt_left_i) begin
          vld_d = 1'b1;
          val_d = ctrl_i.key;
          age_d = '0;
        end else begin
          vld_d = left_i.vld;
          val_d = left_i.val;
          age_d = left_i.age + AGE_W'(1);
        end
      end
    endcase
  end

  // Counts only entries inside the current window, first k of them
  always_comb begin
    in_sum    = vld_q && (LEN_W'(age_q) < ctrl_i.len) && (tok_i.cnt < ctrl_i.k);
    tok_d.acc = tok_i.acc + (in_sum ? SUM_W'(val_q) : '0);
    tok_d.cnt = tok_i.cnt + LEN_W'(in_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
    tok_q <= tok_d;
  end

  assign data_o.vld = vld_q;
  assign data_o.val = val_q;
  assign data_o.age = age_q;
  assign tok_o      = tok_q;

endmodule

// ===== hw/rtl/sliding_window_k_smallest_sum_unit.sv =====
// ---------------------------------------------------------------------------
// sliding_window_k_smallest_sum_unit
// Sum of the keep_count smallest samples over a sliding window.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: a sample
//   and a start flag. A start flag empties the window and the sample opens
//   a new sequence. Once window_len samples have been taken since the last
//   start, each request yields one window_sum on the output channel
//   (out_valid_o / out_stall_i); earlier requests yield nothing.
//   A request passes the DEL state, which evicts the oldest sample from the
//   sorted row of cells once it is full or clears the row on a start, and
//   the INS state, which inserts the new one; when a result is due, the
//   partial sum then ripples through all MAX_WINDOW cells, one cell a cycle.
//   A stalled result sits in the output register; a new request is taken
//   while it waits, and the unit only holds when a second sum is ready.
//   Reset empties the window and sets window_len to 64, keep_count to 1.
//   Configuration writes are taken any time but belong to idle periods.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_k_smallest_sum_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [swks_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [swks_pkg::CFG_W-1:0]       cfg_data_i,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [swks_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                             start_req_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [swks_pkg::SUM_W-1:0]       window_sum_o
);

  import swks_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] window_len_q;
  logic [CFG_W-1:0] keep_count_q;

  // control
  state_e                 state_q, state_d;
  logic [AGE_W-1:0]       wp_q, wp_d;
  logic [LEN_W-1:0]       fill_q, fill_d;
  logic [LEN_W-1:0]       sum_cnt_q, sum_cnt_d;
  logic                   out_vld_q, out_vld_d;
  logic [SUM_W-1:0]       window_sum_q, window_sum_d;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic                   start_q;

  logic                   in_accept;
  logic                   out_free;
  logic [CMP_W-1:0]       wl_ext, kc_ext, len_ext;
  logic [LEN_W-1:0]       eff_len, eff_k;

  // ring store of raw samples; supplies the value being evicted
  logic                   ram_we;
  logic [AGE_W-1:0]       ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // cell row
  cell_ctrl_t             ctrl;
  cell_data_t             cell_data [MAX_WINDOW];
  logic                   cell_lt   [MAX_WINDOW];
  tok_t                   cell_tok  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  vld_vec;
  cell_data_t             edge_data;
  tok_t                   tok_zero;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  // Effective window length: zero reads as one, saturates at MAX_WINDOW.
  // keep_count is clamped to it.
  always_comb begin
    wl_ext = CMP_W'(window_len_q);
    kc_ext = CMP_W'(keep_count_q);
    priority if (wl_ext == '0) begin
      len_ext = CMP_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      len_ext = CMP_W'(MAX_WINDOW);
    end else begin
      len_ext = wl_ext;
    end
    eff_len = LEN_W'(len_ext);
    eff_k   = (kc_ext > len_ext) ? LEN_W'(len_ext) : LEN_W'(kc_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= CFG_W'(64);
      keep_count_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LEN: window_len_q <= cfg_data_i;
        REG_KEEP_COUNT: keep_count_q <= cfg_data_i;
      endcase
    end
  end

  assign ram_waddr = start_q ? '0 : wp_q;

  swks_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (smp_q),
    .re_i    (in_accept),
    .raddr_i (wp_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer: evict or clear, insert, then, when a result is due, let the sum ripple through the row
  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    fill_d       = fill_q;
    sum_cnt_d    = sum_cnt_q;
    out_vld_d    = out_vld_q && out_stall_i;
    window_sum_d = window_sum_q;
    ram_we       = 1'b0;
    ctrl.op      = OP_NOP;
    ctrl.key     = smp_q;
    ctrl.len     = eff_len;
    ctrl.k       = eff_k;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DEL;
        end
      end
      ST_DEL: begin
        ram_we = 1'b1;
        wp_d   = (ram_waddr == AGE_W'(MAX_WINDOW - 1)) ? '0 : ram_waddr + AGE_W'(1);
        if (start_q) begin
          ctrl.op = OP_CLEAR;
          fill_d  = LEN_W'(1);
        end else if (fill_q == LEN_W'(MAX_WINDOW)) begin
          // full: drop the sample written MAX_WINDOW requests ago
          ctrl.op  = OP_DELETE;
          ctrl.key = ram_rdata;
        end else begin
          fill_d = fill_q + LEN_W'(1);
        end
        state_d = ST_INS;
      end
      ST_INS: begin
        ctrl.op   = OP_INSERT;
        sum_cnt_d = '0;
        state_d   = (fill_q >= eff_len) ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (sum_cnt_q == LEN_W'(MAX_WINDOW)) begin
          if (out_free) begin
            out_vld_d    = 1'b1;
            window_sum_d = cell_tok[MAX_WINDOW-1].acc;
            state_d      = ST_IDLE;
          end
        end else begin
          sum_cnt_d = sum_cnt_q + LEN_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      sum_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      sum_cnt_q <= sum_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_sum_q <= window_sum_d;
    if (in_accept) begin
      smp_q   <= sample_i;
      start_q <= start_req_i;
    end
  end

  // Row ends: an empty slot past either end, a zero sum entering cell 0
  assign edge_data.vld = 1'b0;
  assign edge_data.val = '0;
  assign edge_data.age = '0;
  assign tok_zero.acc  = '0;
  assign tok_zero.cnt  = '0;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    swks_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    ((g == 0) ? edge_data : cell_data[(g == 0) ? 0 : g - 1]),
      .right_i   ((g == MAX_WINDOW - 1) ? edge_data :
                  cell_data[(g == MAX_WINDOW - 1) ? g : g + 1]),
      .lt_left_i ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
      .lt_o      (cell_lt[g]),
      .data_o    (cell_data[g]),
      .tok_i     ((g == 0) ? tok_zero : cell_tok[(g == 0) ? 0 : g - 1]),
      .tok_o     (cell_tok[g])
    );
    assign vld_vec[g] = cell_data[g].vld;
  end

  assign out_valid_o  = out_vld_q;
  assign window_sum_o = window_sum_q;

  // A start leaves exactly the new sample behind
  `SWKS_ASSERT_NEXT(a_start_fill, clk_i, rst_ni, (state_q == ST_DEL) && start_q, fill_q == LEN_W'(1), "start did not reset fill count")
  // Between requests the row holds exactly fill_q samples
  `SWKS_ASSERT_NOW(a_row_count, clk_i, rst_ni, state_q == ST_IDLE, $countones(vld_vec) == int'(fill_q), "row occupancy differs from fill count")
  // A result only appears at the end of a sum ripple
  `SWKS_ASSERT_NOW(a_out_from_sum, clk_i, rst_ni, $rose(out_vld_q), $past(state_q) == ST_SUM, "result raised outside sum phase")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench of the sliding-window k-smallest sum unit
// Drives sample requests through randomised valid/stall handshakes, keeps its
// own copy of the window to predict each sum, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import swks_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // slowest request plus margin, used when draining before a register write
  localparam int unsigned DRAIN_CYCLES = MAX_WINDOW + 8;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Window model: ring of recent samples, sorted copy rebuilt per request that yields a sum.
  class sum_scoreboard;
    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    int unsigned            fill;
    int unsigned            wptr;
    logic [CFG_W-1:0]       win_len;
    logic [CFG_W-1:0]       keep_cnt;
    logic [SUM_W-1:0]       pending_sums [$];
    int unsigned            errors;
    int unsigned            requests;
    int unsigned            starts;
    int unsigned            sums_checked;
    int unsigned            settings;

    function new();
      fill         = 0;
      wptr         = 0;
      win_len      = CFG_W'(MAX_WINDOW);
      keep_cnt     = CFG_W'(1);
      errors       = 0;
      requests     = 0;
      starts       = 0;
      sums_checked = 0;
      settings     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_WINDOW_LEN) win_len = data;
      else keep_cnt = data;
      settings++;
    endfunction

    function int unsigned waiting();
      return pending_sums.size();
    endfunction

    // Takes one accepted request; queues a sum once the window is full.
    function void note_request(logic [SAMPLE_BITS-1:0] smp, logic st);
      logic [SAMPLE_BITS-1:0] win [MAX_WINDOW];
      logic [SAMPLE_BITS-1:0] v;
      logic [SUM_W-1:0]       acc;
      int unsigned            len, k, n, i, j, pos;
      requests++;
      if (st) begin
        starts++;
        fill = 0;
        wptr = 0;
      end
      ring[wptr] = smp;
      wptr = (wptr + 1) % MAX_WINDOW;
      if (fill < MAX_WINDOW) fill++;
      // zero length acts as one, oversize saturates
      if (win_len == 0) len = 1;
      else if (win_len > MAX_WINDOW) len = MAX_WINDOW;
      else len = win_len;
      if (fill < len) return;
      // insertion sort of the newest len samples
      pos = wptr;
      n = 0;
      for (i = 0; i < len; i++) begin
        pos = (pos == 0) ? MAX_WINDOW - 1 : pos - 1;
        v = ring[pos];
        j = n;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
        n++;
      end
      k = (keep_cnt > len) ? len : keep_cnt;
      acc = '0;
      for (i = 0; i < k; i++) acc += SUM_W'(win[i]);
      pending_sums.push_back(acc);
    endfunction

    task report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [SUM_W-1:0] got);
      logic [SUM_W-1:0] want;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("window_sum %0d with no request outstanding", got));
      end else begin
        want = pending_sums.pop_front();
        sums_checked++;
        if (got !== want)
          report_mismatch($sformatf("window_sum %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] sample_i;
  logic                   start_req_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [SUM_W-1:0]       window_sum_o;

  sum_scoreboard sb;
  int unsigned   send_idle_pct   = 0;
  int unsigned   stall_pct       = 0;
  int unsigned   hold_cycles_req = 0;
  int unsigned   hold_left       = 0;

  sliding_window_k_smallest_sum_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .start_req_i  (start_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .window_sum_o (window_sum_o)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_cycles_req != 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(window_sum_o);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out after %0d cycles", cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_BITS'($urandom_range(3));         // small values, many ties
      3: return '1 - SAMPLE_BITS'($urandom_range(3));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Offers one request, holding it until the unit accepts it.
  task automatic send_req(logic [SAMPLE_BITS-1:0] smp, logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= smp;
    start_req_i <= st;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(smp, st);
  endtask

  // Drops valid, waits for every predicted sum, then lets the tail run out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [CFG_W-1:0] win, logic [CFG_W-1:0] keep);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WINDOW_LEN;
    cfg_data_i <= win;
    @(posedge clk_i);
    sb.set_reg(REG_WINDOW_LEN, win);
    cfg_idx_i  <= REG_KEEP_COUNT;
    cfg_data_i <= keep;
    @(posedge clk_i);
    sb.set_reg(REG_KEEP_COUNT, keep);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] win, logic [CFG_W-1:0] keep,
                           int unsigned n_items, idle_mode_e mode,
                           int unsigned start_pm, bit max_run, bit hold_off);
    write_config(win, keep);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 69; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 69; end
      default:       begin send_idle_pct = 22; stall_pct = 22; end
    endcase
    // long receiver hold-off: unit fills up and must stall requests
    if (hold_off) hold_cycles_req = 500;
    // run of full-scale samples to reach the top of the sum range
    if (max_run) begin
      send_req('1, 1'b1);
      repeat (MAX_WINDOW + 4) send_req('1, 1'b0);
    end
    repeat (n_items) send_req(pick_sample(), $urandom_range(999) < start_pm);
    settle();
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_WINDOW_LEN;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    start_req_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero window length acts as one; zero keep count sums nothing
    write_config('0, '0);
    send_req('0, 1'b1);
    send_req('1, 1'b0);
    send_req(16'h0001, 1'b0);
    settle();

    // keep count above the window is clamped; window not yet full gives nothing
    write_config(7'd3, 7'd127);
    send_req('1, 1'b1);
    send_req('1, 1'b0);
    send_req('1, 1'b0);
    send_req('0, 1'b0);
    send_req(16'h8000, 1'b0);
    // start part-way through filling restarts the count
    send_req(16'd7, 1'b1);
    send_req(16'd9, 1'b0);
    send_req(16'd7, 1'b1);
    send_req(16'd3, 1'b0);
    send_req(16'd3, 1'b0);
    settle();

    // window lengthened mid-stream, no start
    write_config(7'd4, 7'd2);
    send_req(16'h5555, 1'b0);
    send_req(16'hAAAA, 1'b0);
    settle();

    run_phase(7'd5,   7'd2,   120, IDLE_NONE,     30, 1'b0, 1'b0);
    run_phase(7'd64,  7'd64,  100, IDLE_SENDER,    5, 1'b0, 1'b0);
    run_phase(7'd127, 7'd127,  90, IDLE_RECEIVER,  3, 1'b1, 1'b0);
    run_phase(7'd1,   7'd1,    80, IDLE_BOTH,     50, 1'b0, 1'b0);
    run_phase(7'd16,  7'd0,    80, IDLE_SENDER,   20, 1'b0, 1'b0);
    run_phase(7'd8,   7'd100, 100, IDLE_NONE,     20, 1'b0, 1'b1);
    run_phase(7'd0,   7'd5,    60, IDLE_RECEIVER, 40, 1'b0, 1'b0);
    run_phase(7'd40,  7'd13,  100, IDLE_BOTH,      8, 1'b0, 1'b0);
    run_phase(7'd2,   7'd1,    80, IDLE_RECEIVER, 30, 1'b0, 1'b0);

    $display("Run covered %0d requests (%0d with start) and %0d checked sums,",
             sb.requests, sb.starts, sb.sums_checked);
    $display("over %0d register writes, four idling modes and one long output hold-off.",
             sb.settings);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/swks_pkg.sv
hw/rtl/swks_ram.sv
hw/rtl/swks_cell.sv
hw/rtl/sliding_window_k_smallest_sum_unit.sv
dv/testbench.sv
